### rtl/avr_pkg.sv
// Shared types and constants for the axis-angle vector rotator.
// No dependencies; every other file in rtl/ refers to it by scoped name.
`default_nettype none
package avr_pkg;

  localparam int COMP_W = 32;                 // vector / axis / result component width
  localparam int ANG_IN_W = 32;               // Q4.28 input angle
  localparam int ANG_W = ANG_IN_W + 3;        // Q.30 angle before reduction
  localparam int CZ_W = 33;                   // CORDIC residual angle
  localparam int CXY_W = 34;                  // CORDIC x / y
  localparam int SC_W = 32;                   // cos / sin, Q.30
  localparam int K_W = 32;                    // unit axis component, Q.30

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS = 31;
  localparam int AXIS_LAT = 5 + SQRT_STEPS + DIV_STEPS + 1;
  localparam int SC_DELAY = AXIS_LAT - CORDIC_LAT;
  localparam int COMB_LAT = 6;

  localparam logic signed [ANG_W-1:0] ANG_PI = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 35'sd6746518852;
  localparam logic signed [CXY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [CZ_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    33'sh03243F6A8, 33'sh01DAC6705, 33'sh00FADBAFC, 33'sh007F56EA6, 33'sh003FEAB76,
    33'sh001FFD55B, 33'sh000FFFAAA, 33'sh0007FFF55, 33'sh0003FFFEA, 33'sh0001FFFFD,
    33'sh0000FFFFF, 33'sh00007FFFF, 33'sh00003FFFF, 33'sh00001FFFF, 33'sh00000FFFF,
    33'sh000007FFF, 33'sh000003FFF, 33'sh000001FFF, 33'sh000000FFF, 33'sh0000007FF,
    33'sh0000003FF, 33'sh0000001FF, 33'sh0000000FF, 33'sh00000007F, 33'sh00000003F,
    33'sh00000001F, 33'sh00000000F, 33'sh000000008, 33'sh000000004, 33'sh000000002
  };

  typedef struct packed {
    logic signed [COMP_W-1:0]   vec_x;
    logic signed [COMP_W-1:0]   vec_y;
    logic signed [COMP_W-1:0]   vec_z;
    logic signed [COMP_W-1:0]   axis_x;
    logic signed [COMP_W-1:0]   axis_y;
    logic signed [COMP_W-1:0]   axis_z;
    logic signed [ANG_IN_W-1:0] rot_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic                     zero_axis;
  } out_word_t;

  // vector and unit axis, element 0 is x
  typedef struct packed {
    logic [2:0][COMP_W-1:0] vec;
    logic [2:0][K_W-1:0]    k;
    logic                   zero;
  } norm_word_t;

endpackage
`default_nettype wire

### rtl/avr_cordic.sv
// Angle reduction and pipelined rotation-mode CORDIC, one iteration per stage.
// Depends on avr_pkg.
`default_nettype none
module avr_cordic (
  input  logic                                clk,
  input  logic                                adv,
  input  logic signed [avr_pkg::ANG_IN_W-1:0] angle,
  output logic signed [avr_pkg::SC_W-1:0]     cos_o,
  output logic signed [avr_pkg::SC_W-1:0]     sin_o
);
  localparam int N = avr_pkg::CORDIC_STEPS;

  logic signed [avr_pkg::ANG_W-1:0] z0, z1_r, z2;
  logic                             neg2;
  logic signed [avr_pkg::CXY_W-1:0] x_r [N+1];
  logic signed [avr_pkg::CXY_W-1:0] y_r [N+1];
  logic signed [avr_pkg::CZ_W-1:0]  z_r [N+1];
  logic                             neg_r [N+1];

  always_comb begin
    z0 = {angle[avr_pkg::ANG_IN_W-1], angle, 2'b00};
    z2 = z1_r;
    neg2 = 1'b0;
    if (z1_r > avr_pkg::ANG_HALF_PI) begin
      z2 = z1_r - avr_pkg::ANG_PI;
      neg2 = 1'b1;
    end else if (z1_r < -avr_pkg::ANG_HALF_PI) begin
      z2 = z1_r + avr_pkg::ANG_PI;
      neg2 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (z0 > avr_pkg::ANG_PI) z1_r <= z0 - avr_pkg::ANG_TWO_PI;
      else if (z0 < -avr_pkg::ANG_PI) z1_r <= z0 + avr_pkg::ANG_TWO_PI;
      else z1_r <= z0;
      x_r[0] <= avr_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= avr_pkg::CZ_W'(z2);
      neg_r[0] <= neg2;
      for (int i = 0; i < N; i++) begin
        if (!z_r[i][avr_pkg::CZ_W-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - avr_pkg::ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + avr_pkg::ATAN_TAB[i];
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  // fold the half-turn back in
  assign cos_o = avr_pkg::SC_W'(neg_r[N] ? -x_r[N] : x_r[N]);
  assign sin_o = avr_pkg::SC_W'(neg_r[N] ? -y_r[N] : y_r[N]);

endmodule
`default_nettype wire

### rtl/avr_axis_norm.sv
// Axis normalization pipeline: prescale, sum of squares, square root and
// three restoring dividers, one result bit per stage. Depends on avr_pkg.
`default_nettype none
module avr_axis_norm (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  avr_pkg::in_word_t    in_word,
  output logic                 out_valid,
  output avr_pkg::norm_word_t  out_word
);
  localparam int W = avr_pkg::COMP_W;
  localparam int NSTG = avr_pkg::AXIS_LAT;
  localparam int NSQ = avr_pkg::SQRT_STEPS;
  localparam int NDV = avr_pkg::DIV_STEPS;
  localparam int DV_C = 4 + NSQ;   // carry stage that lines up with the root

  typedef struct packed {
    logic [2:0][W-1:0] vec;
    logic [2:0][W-1:0] mag;
    logic [2:0]        sgn;
    logic              zero;
  } carry_t;

  carry_t            c_r [NSTG];
  logic              v_r [NSTG];
  logic [W-1:0]      m0_r, m1_r;
  logic [2:0][2*W-1:0] sq_r;
  logic [2*W-1:0]    rx_r [NSQ+1];
  logic [2*W-1:0]    rr_r [NSQ+1];
  logic [W-1:0]      dd_r [NDV];
  logic [2:0][W-1:0] rem_r [NDV];
  logic [2:0][NDV-1:0] q_r [NDV];
  logic [2:0][avr_pkg::K_W-1:0] k_r;

  logic [2:0][W-1:0] ax, mag0, mg1, mg2;
  logic [W-1:0]      m0, m1, m2;

  always_comb begin
    ax[0] = in_word.axis_x;
    ax[1] = in_word.axis_y;
    ax[2] = in_word.axis_z;
    for (int i = 0; i < 3; i++) mag0[i] = ax[i][W-1] ? W'(-ax[i]) : ax[i];
    m0 = mag0[0];
    if (mag0[1] > m0) m0 = mag0[1];
    if (mag0[2] > m0) m0 = mag0[2];
  end

  // prescale: coarse shifts
  always_comb begin
    m1 = m0_r;
    mg1 = c_r[0].mag;
    if (m1[W-1:W-17] == '0) begin
      m1 = m1 << 16;
      for (int i = 0; i < 3; i++) mg1[i] = mg1[i] << 16;
    end
    if (m1[W-1:W-9] == '0) begin
      m1 = m1 << 8;
      for (int i = 0; i < 3; i++) mg1[i] = mg1[i] << 8;
    end
  end

  // prescale: fine shifts
  always_comb begin
    m2 = m1_r;
    mg2 = c_r[1].mag;
    if (m2[W-1:W-5] == '0) begin
      m2 = m2 << 4;
      for (int i = 0; i < 3; i++) mg2[i] = mg2[i] << 4;
    end
    if (m2[W-1:W-3] == '0) begin
      m2 = m2 << 2;
      for (int i = 0; i < 3; i++) mg2[i] = mg2[i] << 2;
    end
    if (m2[W-1:W-2] == '0) begin
      for (int i = 0; i < 3; i++) mg2[i] = mg2[i] << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r[0].vec[0] <= in_word.vec_x;
      c_r[0].vec[1] <= in_word.vec_y;
      c_r[0].vec[2] <= in_word.vec_z;
      c_r[0].mag <= mag0;
      for (int i = 0; i < 3; i++) c_r[0].sgn[i] <= ax[i][W-1];
      c_r[0].zero <= (m0 == '0);
      m0_r <= m0;
      c_r[1].vec <= c_r[0].vec;
      c_r[1].sgn <= c_r[0].sgn;
      c_r[1].zero <= c_r[0].zero;
      c_r[1].mag <= mg1;
      m1_r <= m1;
      c_r[2].vec <= c_r[1].vec;
      c_r[2].sgn <= c_r[1].sgn;
      c_r[2].zero <= c_r[1].zero;
      c_r[2].mag <= mg2;
      for (int i = 3; i < NSTG; i++) c_r[i] <= c_r[i-1];
      for (int i = 0; i < 3; i++) sq_r[i] <= (2*W)'(c_r[2].mag[i]) * (2*W)'(c_r[2].mag[i]);
      rx_r[0] <= sq_r[0] + sq_r[1] + sq_r[2];
      rr_r[0] <= '0;
      // square root, two radicand bits per stage
      for (int j = 0; j < NSQ; j++) begin
        if (rx_r[j] >= rr_r[j] + ((2*W)'(1) << (2*W - 2 - 2*j))) begin
          rx_r[j+1] <= rx_r[j] - (rr_r[j] + ((2*W)'(1) << (2*W - 2 - 2*j)));
          rr_r[j+1] <= (rr_r[j] >> 1) + ((2*W)'(1) << (2*W - 2 - 2*j));
        end else begin
          rx_r[j+1] <= rx_r[j];
          rr_r[j+1] <= rr_r[j] >> 1;
        end
      end
    end
  end

  // dividers: quotient of (mag << 30) / root, one bit per stage
  for (genvar j = 0; j < NDV; j++) begin : g_div
    logic [W-1:0]        d_in;
    logic [2:0][W-1:0]   r_in;
    logic [2:0][NDV-1:0] q_in;
    logic [2:0]          nb;
    logic [2:0][W:0]     t;
    logic [2:0]          ge;

    if (j == 0) begin : g_first
      assign d_in = rr_r[NSQ][W-1:0];
      assign q_in = '0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign r_in[i] = {1'b0, c_r[DV_C].mag[i][W-1:1]};
        assign nb[i] = c_r[DV_C].mag[i][0];
      end
    end else begin : g_next
      assign d_in = dd_r[j-1];
      assign r_in = rem_r[j-1];
      assign q_in = q_r[j-1];
      assign nb = '0;
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {r_in[i], nb[i]};
        ge[i] = (t[i] >= {1'b0, d_in});
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dd_r[j] <= d_in;
        for (int i = 0; i < 3; i++) begin
          rem_r[j][i] <= ge[i] ? W'(t[i] - {1'b0, d_in}) : t[i][W-1:0];
          q_r[j][i] <= {q_in[i][NDV-2:0], ge[i]};
        end
      end
    end
  end

  // restore signs, drop the axis for a zero length
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (c_r[NSTG-2].zero) k_r[i] <= '0;
        else if (c_r[NSTG-2].sgn[i]) k_r[i] <= -{1'b0, q_r[NDV-1][i]};
        else k_r[i] <= {1'b0, q_r[NDV-1][i]};
      end
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_word.vec = c_r[NSTG-1].vec;
  assign out_word.k = k_r;
  assign out_word.zero = c_r[NSTG-1].zero;

endmodule
`default_nettype wire

### rtl/avr_combine.sv
// Rodrigues combination: cross and dot products, rounding and saturation
// over six register stages. Depends on avr_pkg.
`default_nettype none
module avr_combine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           in_valid,
  input  avr_pkg::norm_word_t            nw,
  input  logic signed [avr_pkg::SC_W-1:0] cos_i,
  input  logic signed [avr_pkg::SC_W-1:0] sin_i,
  output logic                           out_valid,
  output avr_pkg::out_word_t             out_word
);
  localparam int W = avr_pkg::COMP_W;
  localparam int KW = avr_pkg::K_W;
  localparam int SW = avr_pkg::SC_W;
  localparam int P_W = KW + W;         // k*v and v*cos products
  localparam int CR_W = W + 2;         // cross, dot, v*cos and e after rounding
  localparam int OMC_W = SW + 1;
  localparam int DOM_W = CR_W + OMC_W;
  localparam int CRS_W = CR_W + SW;
  localparam int KE_W = KW + CR_W;
  localparam int R_W = W + 4;
  localparam logic signed [63:0] RND = 64'sd536870912;
  localparam logic signed [OMC_W-1:0] ONE = OMC_W'(64'sd1073741824);
  localparam logic signed [R_W-1:0] SMAX = (R_W'(1) <<< (W - 1)) - R_W'(1);
  localparam logic signed [R_W-1:0] SMIN = -SMAX - R_W'(1);

  logic                     vld_r [avr_pkg::COMB_LAT];
  logic                     z_r   [avr_pkg::COMB_LAT-1];
  logic signed [KW-1:0]     k_r   [avr_pkg::COMB_LAT-2][3];

  logic signed [P_W-1:0]    kv_r [3][3];
  logic signed [P_W-1:0]    vc_r [3];
  logic signed [OMC_W-1:0]  omc1_r, omc2_r;
  logic signed [SW-1:0]     s1_r, s2_r;
  logic signed [CR_W-1:0]   cr_r [3];
  logic signed [CR_W-1:0]   d_r;
  logic signed [CR_W-1:0]   vcr2_r [3];
  logic signed [CR_W-1:0]   vcr3_r [3];
  logic signed [CR_W-1:0]   vcr4_r [3];
  logic signed [DOM_W-1:0]  dom_r;
  logic signed [CRS_W-1:0]  crs_r [3];
  logic signed [CR_W-1:0]   e_r;
  logic signed [CR_W-1:0]   crsr_r [3];
  logic signed [KE_W-1:0]   ke_r [3];
  logic signed [R_W-1:0]    part_r [3];
  logic signed [R_W-1:0]    r [3];
  logic signed [W-1:0]      res_r [3];
  logic                     zero_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r[i] = part_r[i] + R_W'((($signed((KE_W+1)'(ke_r[i])) + (KE_W+1)'(RND)) >>> 30));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < avr_pkg::COMB_LAT; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < avr_pkg::COMB_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // products of axis and vector, vector and cosine
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kv_r[i][j] <= P_W'($signed(nw.k[i])) * P_W'($signed(nw.vec[j]));
        end
        vc_r[i] <= P_W'($signed(nw.vec[i])) * P_W'(cos_i);
        k_r[0][i] <= $signed(nw.k[i]);
      end
      omc1_r <= ONE - OMC_W'(cos_i);
      s1_r <= sin_i;
      z_r[0] <= nw.zero;

      // round cross product, dot product and v*cos
      cr_r[0] <= CR_W'((((P_W+1)'(kv_r[1][2]) - (P_W+1)'(kv_r[2][1])) + (P_W+1)'(RND)) >>> 30);
      cr_r[1] <= CR_W'((((P_W+1)'(kv_r[2][0]) - (P_W+1)'(kv_r[0][2])) + (P_W+1)'(RND)) >>> 30);
      cr_r[2] <= CR_W'((((P_W+1)'(kv_r[0][1]) - (P_W+1)'(kv_r[1][0])) + (P_W+1)'(RND)) >>> 30);
      d_r <= CR_W'(((P_W+2)'(kv_r[0][0]) + (P_W+2)'(kv_r[1][1]) + (P_W+2)'(kv_r[2][2])
                    + (P_W+2)'(RND)) >>> 30);
      for (int i = 0; i < 3; i++) begin
        vcr2_r[i] <= CR_W'(((P_W+1)'(vc_r[i]) + (P_W+1)'(RND)) >>> 30);
        k_r[1][i] <= k_r[0][i];
      end
      omc2_r <= omc1_r;
      s2_r <= s1_r;
      z_r[1] <= z_r[0];

      // d*(1-cos) and cross*sin
      dom_r <= DOM_W'(d_r) * DOM_W'(omc2_r);
      for (int i = 0; i < 3; i++) begin
        crs_r[i] <= CRS_W'(cr_r[i]) * CRS_W'(s2_r);
        vcr3_r[i] <= vcr2_r[i];
        k_r[2][i] <= k_r[1][i];
      end
      z_r[2] <= z_r[1];

      // round both
      e_r <= CR_W'(((DOM_W+1)'(dom_r) + (DOM_W+1)'(RND)) >>> 30);
      for (int i = 0; i < 3; i++) begin
        crsr_r[i] <= CR_W'(((CRS_W+1)'(crs_r[i]) + (CRS_W+1)'(RND)) >>> 30);
        vcr4_r[i] <= vcr3_r[i];
        k_r[3][i] <= k_r[2][i];
      end
      z_r[3] <= z_r[2];

      // k*e and the partial sum
      for (int i = 0; i < 3; i++) begin
        ke_r[i] <= KE_W'(k_r[3][i]) * KE_W'(e_r);
        part_r[i] <= R_W'(vcr4_r[i]) + R_W'(crsr_r[i]);
      end
      z_r[4] <= z_r[3];

      // final sum and saturation
      for (int i = 0; i < 3; i++) begin
        if (r[i] > SMAX) res_r[i] <= W'(SMAX);
        else if (r[i] < SMIN) res_r[i] <= W'(SMIN);
        else res_r[i] <= W'(r[i]);
      end
      zero_r <= z_r[4];
    end
  end

  assign out_valid = vld_r[avr_pkg::COMB_LAT-1];
  assign out_word.out_x = res_r[0];
  assign out_word.out_y = res_r[1];
  assign out_word.out_z = res_r[2];
  assign out_word.zero_axis = zero_r;

endmodule
`default_nettype wire

### rtl/axis_angle_vector_rotate_top.sv
// Top level of the axis-angle vector rotator (Rodrigues' formula, fixed point).
// Depends on avr_pkg, avr_cordic, avr_axis_norm and avr_combine.
//
//   channel  direction  handshake           word
//   in_      input      in_valid/in_stall   avr_pkg::in_word_t  (vector, axis, angle)
//   out_     output     out_valid/out_stall avr_pkg::out_word_t (rotated vector, flag)
//
// One word enters per cycle unless in_stall is high; the result is offered after
// it passes 76 registers, the first loaded at the accepting edge: 69 stages of axis
// normalization (32 square-root and 31 divider stages set the length), 6 stages
// of combination and one output buffer slot.
// Sine and cosine come from a 32-stage CORDIC that runs beside the axis path
// and are held in a 37-deep delay line to meet it.
// Reset clears only valid bits, buffer pointers and the buffer count; the data path is not reset.
// A two-word output buffer decouples the sides: the whole pipeline holds only
// when both buffer slots are full, so in_stall is decoded from the registered buffer count.
`default_nettype none
module axis_angle_vector_rotate_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  avr_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output avr_pkg::out_word_t out_data
);
  localparam int SW = avr_pkg::SC_W;

  logic                      adv;
  logic                      nrm_valid;
  avr_pkg::norm_word_t       nrm_word;
  logic signed [SW-1:0]      cor_cos, cor_sin;
  logic signed [SW-1:0]      cos_dl_r [avr_pkg::SC_DELAY];
  logic signed [SW-1:0]      sin_dl_r [avr_pkg::SC_DELAY];
  logic                      comb_valid;
  avr_pkg::out_word_t        comb_word;

  // output buffer
  avr_pkg::out_word_t        buf_r [2];
  logic                      wr_ptr_r, rd_ptr_r;
  logic [1:0]                cnt_r;
  logic                      push, pop;

  // advance everything unless both buffer slots hold results
  assign adv = (cnt_r != 2'd2);
  assign in_stall = !adv;

  avr_cordic u_cordic (
    .clk   (clk),
    .adv   (adv),
    .angle (in_data.rot_angle),
    .cos_o (cor_cos),
    .sin_o (cor_sin)
  );

  avr_axis_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_word   (in_data),
    .out_valid (nrm_valid),
    .out_word  (nrm_word)
  );

  // delay sine and cosine to line up with the unit axis
  always_ff @(posedge clk) begin
    if (adv) begin
      cos_dl_r[0] <= cor_cos;
      sin_dl_r[0] <= cor_sin;
      for (int i = 1; i < avr_pkg::SC_DELAY; i++) begin
        cos_dl_r[i] <= cos_dl_r[i-1];
        sin_dl_r[i] <= sin_dl_r[i-1];
      end
    end
  end

  avr_combine u_comb (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (nrm_valid),
    .nw        (nrm_word),
    .cos_i     (cos_dl_r[avr_pkg::SC_DELAY-1]),
    .sin_i     (sin_dl_r[avr_pkg::SC_DELAY-1]),
    .out_valid (comb_valid),
    .out_word  (comb_word)
  );

  // drop finished words into the buffer, drain in order
  assign push = adv && comb_valid;
  assign pop = out_valid && !out_stall;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data = buf_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= comb_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // a held input always means a result is on offer
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input held while no result is offered");

  // a result blocked at the end of the pipeline stays there
  a_blocked_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (comb_valid && !adv) |=> comb_valid)
    else $error("blocked pipeline result lost");

  // buffer fill level rises by one on a push without a pop
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("buffer count out of step");

endmodule
`default_nettype wire
